// ===== rtl/adjacency_matrix_graph_store_core_assert.svh =====
// Assertion macros used by the graph store core.
`ifndef ADJACENCY_MATRIX_GRAPH_STORE_CORE_ASSERT_SVH
`define ADJACENCY_MATRIX_GRAPH_STORE_CORE_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define AMG_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Implication checked in the same cycle.
`define AMG_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/amg_pkg.sv =====
// Types, codes and constants of the adjacency matrix graph store.
`default_nettype none

package amg_pkg;

    localparam int VTX_W            = 5;
    localparam int ROWS             = 2 ** VTX_W;
    localparam int VCNT_W           = 6;
    localparam int ECNT_W           = 10;
    localparam int MAX_VERTICES_DEF = 32;

    localparam logic [2:0] OP_ADD_VERTEX = 3'd0;
    localparam logic [2:0] OP_ADD_EDGE   = 3'd1;
    localparam logic [2:0] OP_QUERY_EDGE = 3'd2;
    localparam logic [2:0] OP_LIST_NEIGH = 3'd3;
    localparam logic [2:0] OP_LIST_VERT  = 3'd4;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_PRESENT = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_EDGE_B,
        S_EMIT,
        S_LIST_N,
        S_LIST_V
    } t_state;

    typedef struct packed {
        logic [2:0]       op;
        logic [VTX_W-1:0] vertex_a;
        logic [VTX_W-1:0] vertex_b;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        status;
        logic              edge_found;
        logic [VTX_W-1:0]  item_vertex;
        logic              item_valid;
        logic              last;
        logic [VCNT_W-1:0] vertex_total;
        logic [ECNT_W-1:0] edge_total;
    } t_out_item;

endpackage

`default_nettype wire

// ===== rtl/adjacency_matrix_graph_store_core.sv =====
// Top level of the adjacency matrix graph store: sequencer, memories, output stage.
//
// Usage: one input beat per operation on i_in (valid/ready), results leave on
// o_out (valid/ready), each beat carrying the running vertex and edge totals.
// Operations: add vertex, add edge, query edge, list neighbours, list vertices.
// Single-result operations give one beat with last set; lists give one beat per
// element, the final one marked last; an empty list gives one invalid beat.
// Flow: S_IDLE takes the input beat, S_EXEC decides, and S_EMIT or a list
// state loads the result; a successful edge add of two distinct vertices
// writes the second row in S_EDGE_B first. Throughput: one operation at a
// time, the next input beat taken once the final result beat is loaded into
// the output register. Vertex table listing streams one beat per cycle while
// the output register is free; neighbour listing walks the matrix row one bit
// position per cycle, stopping at a set bit while the output register is full.
// Reset clears the present map, counts, sequencer and the per-row valid bits of
// the matrix memory (an unwritten row reads as zero), so no clearing pass is
// needed and the block is ready the cycle after reset is released.
// Receiver stall: the output register holds its beat, the sequencer waits with
// the list position frozen; nothing is dropped or repeated.
`default_nettype none

`include "adjacency_matrix_graph_store_core_assert.svh"

module adjacency_matrix_graph_store_core #(
    parameter int MAX_VERTICES = amg_pkg::MAX_VERTICES_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire amg_pkg::t_in_item  i_in,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output amg_pkg::t_out_item      o_out
);

    import amg_pkg::*;

    // vertex table holds at most one entry per vertex number
    localparam int                CAPACITY = (MAX_VERTICES < ROWS) ? MAX_VERTICES : ROWS;
    localparam int                ORD_AW   = $clog2(CAPACITY);
    localparam logic [VCNT_W:0]   MAX_V    = (VCNT_W + 1)'(MAX_VERTICES);
    localparam logic [VCNT_W-1:0] CAP_CNT  = VCNT_W'(CAPACITY);

    // control state
    t_state            r_state, n_state;
    logic [ROWS-1:0]   r_present, n_present;
    logic [VCNT_W-1:0] r_vcount, n_vcount;
    logic [ECNT_W-1:0] r_ecount, n_ecount;
    logic [ROWS-1:0]   r_row_valid, n_row_valid;
    logic              r_rdv;

    // operation context
    logic [2:0]        r_op, n_op;
    logic [VTX_W-1:0]  r_a, n_a;
    logic [VTX_W-1:0]  r_b, n_b;
    logic [VCNT_W-1:0] r_idx, n_idx;
    logic [ROWS-1:0]   r_row, n_row;
    logic [1:0]        r_status, n_status;
    logic              r_found, n_found;

    // memory ports
    logic              adj_we, adj_re;
    logic [VTX_W-1:0]  adj_waddr, adj_raddr;
    logic [ROWS-1:0]   adj_wdata, adj_rdata, rd_row;
    logic              ord_we, ord_re;
    logic [ORD_AW-1:0] ord_waddr, ord_raddr;
    logic [VTX_W-1:0]  ord_wdata, ord_rdata;

    // output stage
    logic              out_free, out_load;
    t_out_item         out_beat;

    logic              pres_a, pres_b;
    logic [ROWS-1:0]   sel_bit;
    logic [VCNT_W-1:0] idx_next;

    amg_ram #(
        .WIDTH (ROWS),
        .DEPTH (ROWS)
    ) u_adj_ram (
        .i_clk     (i_clk),
        .i_wr_en   (adj_we),
        .i_wr_addr (adj_waddr),
        .i_wr_data (adj_wdata),
        .i_rd_en   (adj_re),
        .i_rd_addr (adj_raddr),
        .o_rd_data (adj_rdata)
    );

    amg_ram #(
        .WIDTH (VTX_W),
        .DEPTH (CAPACITY)
    ) u_ord_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ord_we),
        .i_wr_addr (ord_waddr),
        .i_wr_data (ord_wdata),
        .i_rd_en   (ord_re),
        .i_rd_addr (ord_raddr),
        .o_rd_data (ord_rdata)
    );

    amg_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (out_load),
        .i_beat  (out_beat),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .o_beat  (o_out),
        .i_ready (i_out_ready)
    );

    // a row never written reads as all zero
    assign rd_row   = r_rdv ? adj_rdata : '0;
    assign pres_a   = r_present[r_a];
    assign pres_b   = r_present[r_b];
    assign sel_bit  = ROWS'(1) << r_idx[VTX_W-1:0];
    assign idx_next = r_idx + VCNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_present   <= '0;
            r_vcount    <= '0;
            r_ecount    <= '0;
            r_row_valid <= '0;
            r_rdv       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_present   <= n_present;
            r_vcount    <= n_vcount;
            r_ecount    <= n_ecount;
            r_row_valid <= n_row_valid;
            if (adj_re) begin
                r_rdv <= r_row_valid[adj_raddr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_a      <= n_a;
        r_b      <= n_b;
        r_idx    <= n_idx;
        r_row    <= n_row;
        r_status <= n_status;
        r_found  <= n_found;
    end

    always_comb begin
        n_state     = r_state;
        n_present   = r_present;
        n_vcount    = r_vcount;
        n_ecount    = r_ecount;
        n_row_valid = r_row_valid;
        n_op        = r_op;
        n_a         = r_a;
        n_b         = r_b;
        n_idx       = r_idx;
        n_row       = r_row;
        n_status    = r_status;
        n_found     = r_found;

        adj_we      = 1'b0;
        adj_waddr   = r_a;
        adj_wdata   = rd_row;
        adj_re      = 1'b0;
        adj_raddr   = r_b;
        ord_we      = 1'b0;
        ord_waddr   = r_vcount[ORD_AW-1:0];
        ord_wdata   = r_a;
        ord_re      = 1'b0;
        ord_raddr   = idx_next[ORD_AW-1:0];

        o_in_ready  = 1'b0;
        out_load    = 1'b0;
        out_beat    = '{status:       r_status,
                        edge_found:   r_found,
                        item_vertex:  '0,
                        item_valid:   1'b0,
                        last:         1'b1,
                        vertex_total: r_vcount,
                        edge_total:   r_ecount};

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_op      = i_in.op;
                    n_a       = i_in.vertex_a;
                    n_b       = i_in.vertex_b;
                    // row a and the head of the vertex table come back next cycle
                    adj_re    = 1'b1;
                    adj_raddr = i_in.vertex_a;
                    ord_re    = 1'b1;
                    ord_raddr = '0;
                    n_state   = S_EXEC;
                end
            end

            S_EXEC: begin
                n_status = ST_DONE;
                n_found  = 1'b0;
                n_state  = S_EMIT;
                case (r_op)
                    OP_ADD_VERTEX: begin
                        if (pres_a) begin
                            n_status = ST_PRESENT;
                        end else if ({2'b00, r_a} >= MAX_V || r_vcount >= CAP_CNT) begin
                            n_status = ST_UNKNOWN;
                        end else begin
                            ord_we         = 1'b1;
                            n_vcount       = r_vcount + VCNT_W'(1);
                            n_present[r_a] = 1'b1;
                        end
                    end
                    OP_ADD_EDGE: begin
                        if (!pres_a || !pres_b) begin
                            n_status = ST_UNKNOWN;
                        end else if (rd_row[r_b]) begin
                            n_status = ST_PRESENT;
                        end else begin
                            adj_we           = 1'b1;
                            adj_waddr        = r_a;
                            adj_wdata        = rd_row | (ROWS'(1) << r_b);
                            n_row_valid[r_a] = 1'b1;
                            n_ecount         = r_ecount + ECNT_W'(1);
                            // self loop sets a single bit
                            if (r_a != r_b) begin
                                adj_re    = 1'b1;
                                adj_raddr = r_b;
                                n_state   = S_EDGE_B;
                            end
                        end
                    end
                    OP_QUERY_EDGE: begin
                        if (!pres_a || !pres_b) begin
                            n_status = ST_UNKNOWN;
                        end else begin
                            n_found = rd_row[r_b];
                        end
                    end
                    OP_LIST_NEIGH: begin
                        if (!pres_a) begin
                            n_status = ST_UNKNOWN;
                        end else if (rd_row != '0) begin
                            n_row   = rd_row;
                            n_idx   = '0;
                            n_state = S_LIST_N;
                        end
                    end
                    OP_LIST_VERT: begin
                        if (r_vcount != '0) begin
                            n_idx   = '0;
                            n_state = S_LIST_V;
                        end
                    end
                    default: begin
                        n_status = ST_DONE;
                    end
                endcase
            end

            S_EDGE_B: begin
                adj_we           = 1'b1;
                adj_waddr        = r_b;
                adj_wdata        = rd_row | (ROWS'(1) << r_a);
                n_row_valid[r_b] = 1'b1;
                n_state          = S_EMIT;
            end

            S_EMIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            S_LIST_N: begin
                // remaining neighbours are the bits still set in r_row
                if (r_row[r_idx[VTX_W-1:0]]) begin
                    if (out_free) begin
                        out_load             = 1'b1;
                        out_beat.status      = ST_DONE;
                        out_beat.edge_found  = 1'b0;
                        out_beat.item_vertex = r_idx[VTX_W-1:0];
                        out_beat.item_valid  = 1'b1;
                        out_beat.last        = (r_row & ~sel_bit) == '0;
                        n_row                = r_row & ~sel_bit;
                        n_idx                = idx_next;
                        if ((r_row & ~sel_bit) == '0) begin
                            n_state = S_IDLE;
                        end
                    end
                end else begin
                    n_idx = idx_next;
                end
            end

            S_LIST_V: begin
                if (out_free) begin
                    out_load             = 1'b1;
                    out_beat.status      = ST_DONE;
                    out_beat.edge_found  = 1'b0;
                    out_beat.item_vertex = ord_rdata;
                    out_beat.item_valid  = 1'b1;
                    out_beat.last        = idx_next == r_vcount;
                    // fetch the next entry while this one leaves
                    ord_re               = 1'b1;
                    n_idx                = idx_next;
                    if (idx_next == r_vcount) begin
                        n_state = S_IDLE;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // checks on the sequencer and bookkeeping
    `AMG_ASSERT_ALWAYS(a_vcount_cap, r_vcount <= CAP_CNT, "vertex count above capacity")
    `AMG_ASSERT_ALWAYS(a_present_count, $countones(r_present) == int'(r_vcount), "present map and vertex count disagree")
    `AMG_ASSERT_IMP(a_list_row_live, r_state == S_LIST_N, r_row != '0, "neighbour scan on an empty row")
    `AMG_ASSERT_IMP(a_edge_b_distinct, r_state == S_EDGE_B, r_a != r_b, "second row write for a self loop")

endmodule

`default_nettype wire

// ===== rtl/amg_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read port.
`default_nettype none

module amg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== rtl/amg_out_reg.sv =====
// Output beat register between the sequencer and the result channel.
`default_nettype none

module amg_out_reg (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_load,
    input  wire amg_pkg::t_out_item i_beat,
    output logic                    o_free,
    output logic                    o_valid,
    output amg_pkg::t_out_item      o_beat,
    input  wire logic               i_ready
);

    import amg_pkg::*;

    logic      r_valid;
    t_out_item r_beat;

    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_beat <= i_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

`default_nettype wire
